@@ rtl/asc_pkg.sv @@
package asc_pkg;

    localparam int KindW = 5;
    localparam int PosW  = 6;
    localparam int StatW = 2;
    localparam int RomW  = 5;

    // Token kind codes.
    localparam logic [KindW-1:0] K_MEM    = 5'd0;
    localparam logic [KindW-1:0] K_MID    = 5'd1;
    localparam logic [KindW-1:0] K_NUM    = 5'd2;
    localparam logic [KindW-1:0] K_REG    = 5'd3;
    localparam logic [KindW-1:0] K_RID    = 5'd4;
    localparam logic [KindW-1:0] K_FUNC   = 5'd5;
    localparam logic [KindW-1:0] K_ID     = 5'd6;
    localparam logic [KindW-1:0] K_COLON  = 5'd7;
    localparam logic [KindW-1:0] K_SEMI   = 5'd8;
    localparam logic [KindW-1:0] K_EOF    = 5'd9;
    localparam logic [KindW-1:0] K_ADD    = 5'd10;
    localparam logic [KindW-1:0] K_ADDI   = 5'd11;
    localparam logic [KindW-1:0] K_SUB    = 5'd12;
    localparam logic [KindW-1:0] K_LA     = 5'd13;
    localparam logic [KindW-1:0] K_LW     = 5'd14;
    localparam logic [KindW-1:0] K_LI     = 5'd15;
    localparam logic [KindW-1:0] K_SW     = 5'd16;
    localparam logic [KindW-1:0] K_B      = 5'd17;
    localparam logic [KindW-1:0] K_BLTZ   = 5'd18;
    localparam logic [KindW-1:0] K_NOP    = 5'd19;
    localparam logic [KindW-1:0] K_JAL    = 5'd20;
    localparam logic [KindW-1:0] K_AND    = 5'd21;
    localparam logic [KindW-1:0] K_ANDI   = 5'd22;
    localparam logic [KindW-1:0] K_COMMA  = 5'd23;
    localparam logic [KindW-1:0] K_LPAREN = 5'd24;
    localparam logic [KindW-1:0] K_RPAREN = 5'd25;

    // Result status codes.
    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_DONE    = 2'd1;
    localparam logic [StatW-1:0] ST_ERROR   = 2'd2;
    localparam logic [StatW-1:0] ST_SKIPPED = 2'd3;

    // Grammar positions. Positions from POS_ROM up to POS_ROM_END walk the operand sequence table.
    localparam logic [PosW-1:0] POS_FIRST = 6'd0;
    localparam logic [PosW-1:0] POS_NEXT  = 6'd1;
    localparam logic [PosW-1:0] POS_LABEL = 6'd2;
    localparam logic [PosW-1:0] POS_SEMI  = 6'd3;
    localparam logic [PosW-1:0] POS_COLON = 6'd4;
    localparam logic [PosW-1:0] POS_ROM   = 6'd5;
    localparam int RomLen = 29;
    localparam logic [PosW-1:0] POS_ROM_END = POS_ROM + PosW'(RomLen);

    // Starting offsets of the operand sequences.
    localparam logic [PosW-1:0] SEQ_MEM   = 6'd0;
    localparam logic [PosW-1:0] SEQ_REG   = 6'd2;
    localparam logic [PosW-1:0] SEQ_NAME  = 6'd3;
    localparam logic [PosW-1:0] SEQ_RRR   = 6'd4;
    localparam logic [PosW-1:0] SEQ_RRN   = 6'd9;
    localparam logic [PosW-1:0] SEQ_LA    = 6'd14;
    localparam logic [PosW-1:0] SEQ_MEMOP = 6'd17;
    localparam logic [PosW-1:0] SEQ_LI    = 6'd23;
    localparam logic [PosW-1:0] SEQ_BLTZ  = 6'd26;

    typedef struct packed {
        logic [PosW-1:0]  pos;
        logic             skip;
        logic [StatW-1:0] status;
        logic [KindW-1:0] offending;
    } asc_step_t;

    // Expected kind at each entry of the operand sequence table.
    function automatic logic [KindW-1:0] rom_kind(input logic [RomW-1:0] idx);
        logic [KindW-1:0] k;
        case (idx)
            5'd0:    k = K_MID;
            5'd1:    k = K_NUM;
            5'd2:    k = K_RID;
            5'd3:    k = K_ID;
            5'd4:    k = K_RID;
            5'd5:    k = K_COMMA;
            5'd6:    k = K_RID;
            5'd7:    k = K_COMMA;
            5'd8:    k = K_RID;
            5'd9:    k = K_RID;
            5'd10:   k = K_COMMA;
            5'd11:   k = K_RID;
            5'd12:   k = K_COMMA;
            5'd13:   k = K_NUM;
            5'd14:   k = K_RID;
            5'd15:   k = K_COMMA;
            5'd16:   k = K_MID;
            5'd17:   k = K_RID;
            5'd18:   k = K_COMMA;
            5'd19:   k = K_NUM;
            5'd20:   k = K_LPAREN;
            5'd21:   k = K_RID;
            5'd22:   k = K_RPAREN;
            5'd23:   k = K_RID;
            5'd24:   k = K_COMMA;
            5'd25:   k = K_NUM;
            5'd26:   k = K_RID;
            5'd27:   k = K_COMMA;
            5'd28:   k = K_ID;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    // True where an entry closes its sequence and a semicolon follows.
    function automatic logic rom_last(input logic [RomW-1:0] idx);
        logic l;
        case (idx)
            5'd1, 5'd2, 5'd3, 5'd8, 5'd13, 5'd16, 5'd22, 5'd25, 5'd28: l = 1'b1;
            default: l = 1'b0;
        endcase
        return l;
    endfunction

endpackage

@@ rtl/asc_step.sv @@
module asc_step (
    input  logic [asc_pkg::PosW-1:0]  pos,
    input  logic                      skip,
    input  logic [asc_pkg::KindW-1:0] kind,
    output asc_pkg::asc_step_t        step
);
    import asc_pkg::*;

    logic             ok;
    logic             done;
    logic [PosW-1:0]  next_pos;
    logic             instr_ok;
    logic [PosW-1:0]  instr_pos;
    logic             stmt_ok;
    logic [PosW-1:0]  stmt_pos;
    logic [RomW-1:0]  rom_idx;
    logic [PosW-1:0]  rom_off;

    // Position after an instruction keyword.
    always_comb begin
        instr_ok  = 1'b1;
        instr_pos = POS_FIRST;
        case (kind)
            K_ADD, K_SUB, K_AND: instr_pos = POS_ROM + SEQ_RRR;
            K_ADDI, K_ANDI:      instr_pos = POS_ROM + SEQ_RRN;
            K_LA:                instr_pos = POS_ROM + SEQ_LA;
            K_LW, K_SW:          instr_pos = POS_ROM + SEQ_MEMOP;
            K_LI:                instr_pos = POS_ROM + SEQ_LI;
            K_B, K_JAL:          instr_pos = POS_ROM + SEQ_NAME;
            K_BLTZ:              instr_pos = POS_ROM + SEQ_BLTZ;
            K_NOP:               instr_pos = POS_SEMI;
            default:             instr_ok  = 1'b0;
        endcase
    end

    // Position after the first token of a statement.
    always_comb begin
        stmt_ok  = 1'b1;
        stmt_pos = POS_FIRST;
        case (kind)
            K_MEM:   stmt_pos = POS_ROM + SEQ_MEM;
            K_REG:   stmt_pos = POS_ROM + SEQ_REG;
            K_FUNC:  stmt_pos = POS_ROM + SEQ_NAME;
            K_ID:    stmt_pos = POS_COLON;
            default: begin
                stmt_ok  = instr_ok;
                stmt_pos = instr_pos;
            end
        endcase
    end

    assign rom_off = pos - POS_ROM;
    assign rom_idx = rom_off[RomW-1:0];

    always_comb begin
        done     = 1'b0;
        ok       = 1'b0;
        next_pos = POS_FIRST;
        if (pos == POS_NEXT && kind == K_EOF) begin
            ok   = 1'b1;
            done = 1'b1;
        end else if (pos == POS_NEXT || pos == POS_FIRST) begin
            ok       = stmt_ok;
            next_pos = stmt_pos;
        end else if (pos == POS_LABEL) begin
            ok       = instr_ok;
            next_pos = instr_pos;
        end else if (pos == POS_SEMI) begin
            ok       = (kind == K_SEMI);
            next_pos = POS_NEXT;
        end else if (pos == POS_COLON) begin
            ok       = (kind == K_COLON);
            next_pos = POS_LABEL;
        end else if (pos < POS_ROM_END) begin
            ok       = (kind == rom_kind(rom_idx));
            next_pos = rom_last(rom_idx) ? POS_SEMI : pos + PosW'(1);
        end else begin
            // Unused position codes behave as the start of a first statement.
            ok       = stmt_ok;
            next_pos = stmt_pos;
        end
    end

    always_comb begin
        if (skip) begin
            step.pos       = (kind == K_EOF) ? POS_FIRST : pos;
            step.skip      = (kind != K_EOF);
            step.status    = ST_SKIPPED;
            step.offending = '0;
        end else if (ok) begin
            step.pos       = next_pos;
            step.skip      = 1'b0;
            step.status    = done ? ST_DONE : ST_OK;
            step.offending = '0;
        end else begin
            // An error on eof restarts at once; any other kind skips to eof.
            step.pos       = POS_FIRST;
            step.skip      = (kind != K_EOF);
            step.status    = ST_ERROR;
            step.offending = kind;
        end
    end

endmodule

@@ rtl/assembly_token_syntax_checker_top.sv @@
// An accepted token's result is registered and reaches the master side next cycle.
// Throughput: one token per cycle while m_tready is high; position and skip flag
// advance in a single registered step, and the result register frees as it is read.
// Reset (aresetn low, synchronous): the grammar returns to the start of a
// first statement, skipping is cleared and no result is pending.
module assembly_token_syntax_checker_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] token_kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] offending_kind
    output logic [1:0] m_tuser    // [1:0] status
);
    import asc_pkg::*;

    logic [PosW-1:0]  pos_reg;
    logic             skip_reg;
    logic             valid_reg;
    logic [StatW-1:0] status_reg;
    logic [KindW-1:0] offending_reg;
    logic             take;
    asc_step_t        step;

    asc_step u_step (
        .pos  (pos_reg),
        .skip (skip_reg),
        .kind (s_tdata[KindW-1:0]),
        .step (step)
    );

    // A new request is taken whenever the result register is empty or being read.
    assign s_tready = !valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_FIRST;
            skip_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                pos_reg  <= step.pos;
                skip_reg <= step.skip;
            end
            if (take) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg    <= step.status;
            offending_reg <= step.offending;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(8 - KindW)'(0), offending_reg};
    assign m_tuser  = status_reg;

endmodule
